/* hdl/srpg_pkg.sv */
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared widths, reset values, command codes and register indexes of the
// stepper ramp pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package srpg_pkg;

  localparam int SIZE_W            = 40;  // Q24.16 step size
  localparam int ACCEL_W           = 24;  // Q16.8 acceleration
  localparam int DIV_W             = 64;  // dividend and quotient of the serial divider
  localparam int MUL_W             = 31;  // speed magnitude
  localparam int POSITION_BITS_DEF = 32;

  localparam logic [SIZE_W-1:0]  INIT_SIZE_RST = 40'd62653136896;
  localparam logic [SIZE_W-1:0]  MIN_SIZE_RST  = 40'd65536;
  localparam logic [ACCEL_W-1:0] ACCEL_RST     = 24'd256;
  localparam logic [SIZE_W-1:0]  SIZE_MAX      = {SIZE_W{1'b1}};
  localparam logic [DIV_W-1:0]   SPEED_NUM     = 64'd1000000 << 24;
  localparam logic [MUL_W-1:0]   SAT31         = {MUL_W{1'b1}};

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_MOVE     = 3'd1;
  localparam logic [2:0] CMD_SET_POS  = 3'd2;
  localparam logic [2:0] CMD_STOP     = 3'd3;
  localparam logic [2:0] CMD_STOP_NOW = 3'd4;

  localparam logic [1:0] REG_INIT_SIZE = 2'd0;
  localparam logic [1:0] REG_MIN_SIZE  = 2'd1;
  localparam logic [1:0] REG_ACCEL     = 2'd2;
  localparam logic [1:0] REG_REVERSE   = 2'd3;

endpackage

`default_nettype wire

/* hdl/srpg_mul.sv */
// ----------------------------------------------------------------------------
// srpg_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srpg_mul (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [srpg_pkg::MUL_W-1:0]   mcand,
  input  wire logic [srpg_pkg::MUL_W-1:0]   mplier,
  output logic                              busy,
  output logic                              done,
  output logic [2*srpg_pkg::MUL_W-1:0]      product
);

  localparam int N   = srpg_pkg::MUL_W;
  localparam int CNT = $clog2(N);

  logic [2*N-1:0] prod;
  logic [N-1:0]   mc;
  logic [CNT-1:0] cnt;
  logic [N:0]     upper;

  assign upper   = {1'b0, prod[2*N-1:N]} + (prod[0] ? {1'b0, mc} : '0);
  assign product = prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT'(N-1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= {{N{1'b0}}, mplier};
      mc   <= mcand;
      cnt  <= '0;
    end else if (busy) begin
      prod <= {upper, prod[N-1:1]};
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

`default_nettype wire

/* hdl/srpg_div.sv */
// ----------------------------------------------------------------------------
// srpg_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srpg_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [srpg_pkg::DIV_W-1:0]    dividend,
  input  wire logic [srpg_pkg::SIZE_W-1:0]   divisor,
  output logic                               busy,
  output logic                               done,
  output logic [srpg_pkg::DIV_W-1:0]         quotient
);

  localparam int DW  = srpg_pkg::DIV_W;
  localparam int VW  = srpg_pkg::SIZE_W;
  localparam int CNT = $clog2(DW);

  logic [DW-1:0]  acc;  // dividend bits shift out, quotient bits shift in
  logic [VW-1:0]  rem;
  logic [VW-1:0]  dsr;
  logic [CNT-1:0] cnt;
  logic [VW:0]    trial;
  logic [VW:0]    diff;
  logic           ge;

  assign trial    = {rem, acc[DW-1]};
  assign diff     = trial - {1'b0, dsr};
  assign ge       = trial >= {1'b0, dsr};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT'(DW-1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dsr <= divisor;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
      acc <= {acc[DW-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

`default_nettype wire

/* hdl/stepper_ramp_pulse_generator_top.sv */
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator_top
// Step pulse generator with real-time acceleration ramp.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A tick with no step, and the
// set position, stop now and unused commands, use neither the multiplier nor
// the divider. A tick that steps, a move and a smooth stop recompute the ramp:
// a serial squaring of the speed and up to three serial divisions through one
// shared one-bit-per-cycle divider.
// The next transaction is taken once the result sits in the output register.
`default_nettype none

module stepper_ramp_pulse_generator_top #(
  parameter int POSITION_BITS = srpg_pkg::POSITION_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [srpg_pkg::SIZE_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    command,
  input  wire logic signed [31:0]            value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               step_pulse,
  output logic                               dir_level,
  output logic signed [31:0]                 position,
  output logic                               moving
);

  localparam int SW  = srpg_pkg::SIZE_W;
  localparam int MW  = srpg_pkg::MUL_W;
  localparam int DW  = srpg_pkg::DIV_W;
  localparam int PB  = POSITION_BITS;
  localparam int CW  = ((PB > 32) ? PB : 32) + 2;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_EXEC     = 9'b000000010,
    S_MUL      = 9'b000000100,
    S_DIV_STS  = 9'b000001000,
    S_DECIDE   = 9'b000010000,
    S_DIV_SIZE = 9'b000100000,
    S_SIZE     = 9'b001000000,
    S_DIV_SPD  = 9'b010000000,
    S_FIN      = 9'b100000000
  } state_t;

  state_t state;

  logic [SW-1:0]                       init_size;
  logic [SW-1:0]                       min_size;
  logic [srpg_pkg::ACCEL_W-1:0]        accel;
  logic                                reverse;

  logic signed [PB-1:0]                cur;
  logic signed [PB-1:0]                target;
  logic signed [31:0]                  ramp;
  logic [SW-1:0]                       last_size;
  logic [23:0]                         step_interval;
  logic [31:0]                         elapsed;
  logic [MW-1:0]                       speed_mag;
  logic                                direction;

  logic [2:0]                          cmd_r;
  logic signed [PB-1:0]                val_r;
  logic                                pulse_r;
  logic                                step_dir_r;
  logic [MW-1:0]                       sts;
  logic signed [31:0]                  n_work;
  logic [SW-1:0]                       size_work;

  logic                                mul_start;
  logic                                mul_busy;
  logic                                mul_done;
  logic [2*MW-1:0]                     mul_product;
  logic                                div_start;
  logic                                div_busy;
  logic                                div_done;
  logic [DW-1:0]                       div_dividend;
  logic [SW-1:0]                       div_divisor;
  logic [DW-1:0]                       div_q;

  logic [31:0]                         elapsed_inc;
  logic                                step_due;
  logic [srpg_pkg::ACCEL_W-1:0]        accel_eff;
  logic [MW-1:0]                       sts_q;
  logic [MW-1:0]                       sp_q;

  logic signed [PB-1:0]                dist_p;
  logic signed [CW-1:0]                tgt_dist;
  logic signed [CW-1:0]                absd;
  logic signed [CW-1:0]                sts_c;
  logic signed [32:0]                  n_cand;
  logic signed [31:0]                  n_sat;
  logic signed [34:0]                  n4;
  logic [33:0]                         mag4;
  logic                                stop_here;
  logic [SW-1:0]                       floor_size;
  logic [SW-1:0]                       first_size;
  logic [42:0]                         ns;
  logic [SW-1:0]                       ns_clamped;
  logic [SW-1:0]                       c2_unused_guard;

  assign in_stall  = (state != S_IDLE);
  assign accel_eff = (accel == '0) ? srpg_pkg::ACCEL_W'(1) : accel;
  assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 32'd1;
  assign step_due  = (step_interval != '0) && (elapsed_inc >= 32'(step_interval));
  assign sts_q     = (div_q[DW-1:MW] != '0) ? srpg_pkg::SAT31 : div_q[MW-1:0];
  assign sp_q      = sts_q;
  assign floor_size = (min_size == '0) ? SW'(1) : min_size;
  assign first_size = (init_size == '0) ? SW'(1) : init_size;
  assign c2_unused_guard = last_size;

  // ramp direction decision
  always_comb begin
    dist_p    = target - cur;
    tgt_dist  = CW'(dist_p);
    absd      = (tgt_dist < 0) ? -tgt_dist : tgt_dist;
    sts_c     = signed'(CW'(sts));
    stop_here = (tgt_dist == 0) && (sts <= MW'(1));
    n_cand    = 33'(ramp);
    if (tgt_dist > 0) begin
      if (ramp > 0 && (tgt_dist <= sts_c || direction)) begin
        n_cand = -signed'(33'(sts));
      end else if (ramp < 0 && !direction && tgt_dist > sts_c) begin
        n_cand = -33'(ramp);
      end
    end else if (tgt_dist < 0) begin
      if (ramp > 0 && (absd <= sts_c || !direction)) begin
        n_cand = -signed'(33'(sts));
      end else if (ramp < 0 && direction && absd > sts_c) begin
        n_cand = -33'(ramp);
      end
    end
    n_sat = (n_cand > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF : n_cand[31:0];
    n4    = (35'(n_sat) <<< 2) + 35'sd1;
    mag4  = (n4 < 0) ? 34'(-n4) : 34'(n4);
  end

  // new step size from the quotient 2c/|4n+1|
  always_comb begin
    if (n_work[31]) begin
      ns = {3'b0, c2_unused_guard} + {2'b0, div_q[SW:0]};
    end else begin
      ns = {3'b0, c2_unused_guard} - {2'b0, div_q[SW:0]};
    end
    if ($signed(ns) < $signed({3'b0, floor_size})) begin
      ns_clamped = floor_size;
    end else if (ns > {3'b0, srpg_pkg::SIZE_MAX}) begin
      ns_clamped = srpg_pkg::SIZE_MAX;
    end else begin
      ns_clamped = ns[SW-1:0];
    end
  end

  always_comb begin
    mul_start    = (state == S_EXEC) &&
                   ((cmd_r == srpg_pkg::CMD_TICK && step_due) ||
                    cmd_r == srpg_pkg::CMD_MOVE || cmd_r == srpg_pkg::CMD_STOP);
    div_start    = 1'b0;
    div_dividend = DW'({mul_product});
    div_divisor  = SW'({accel_eff, 9'b0});
    case (state)
      S_MUL: begin
        div_start = mul_done;
      end
      S_DECIDE: begin
        div_start    = !stop_here && (n_sat != 0);
        div_dividend = DW'({last_size, 1'b0});
        div_divisor  = SW'(mag4);
      end
      S_SIZE: begin
        div_start    = 1'b1;
        div_dividend = srpg_pkg::SPEED_NUM;
        div_divisor  = size_work;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      init_size     <= srpg_pkg::INIT_SIZE_RST;
      min_size      <= srpg_pkg::MIN_SIZE_RST;
      accel         <= srpg_pkg::ACCEL_RST;
      reverse       <= 1'b0;
      cur           <= '0;
      target        <= '0;
      ramp          <= '0;
      last_size     <= srpg_pkg::INIT_SIZE_RST;
      step_interval <= '0;
      elapsed       <= '0;
      speed_mag     <= '0;
      direction     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          srpg_pkg::REG_INIT_SIZE: init_size <= cfg_data;
          srpg_pkg::REG_MIN_SIZE:  min_size  <= cfg_data;
          srpg_pkg::REG_ACCEL:     accel     <= cfg_data[srpg_pkg::ACCEL_W-1:0];
          srpg_pkg::REG_REVERSE:   reverse   <= cfg_data[0];
          default:                 reverse   <= reverse;
        endcase
      end
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= command;
            val_r   <= PB'(value);
            pulse_r <= 1'b0;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          step_dir_r <= direction;
          case (cmd_r)
            srpg_pkg::CMD_TICK: begin
              if (step_due) begin
                pulse_r <= 1'b1;
                cur     <= direction ? cur - PB'(1) : cur + PB'(1);
                elapsed <= '0;
                state   <= S_MUL;
              end else begin
                elapsed <= elapsed_inc;
                state   <= S_FIN;
              end
            end
            srpg_pkg::CMD_MOVE: begin
              target <= val_r;
              state  <= S_MUL;
            end
            srpg_pkg::CMD_SET_POS: begin
              cur           <= val_r;
              target        <= val_r;
              ramp          <= '0;
              step_interval <= '0;
              speed_mag     <= '0;
              state         <= S_FIN;
            end
            srpg_pkg::CMD_STOP: begin
              state <= S_MUL;
            end
            srpg_pkg::CMD_STOP_NOW: begin
              target        <= cur;
              ramp          <= '0;
              step_interval <= '0;
              speed_mag     <= '0;
              state         <= S_FIN;
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        S_MUL: begin
          if (mul_done) state <= S_DIV_STS;
        end
        S_DIV_STS: begin
          if (div_done) begin
            sts <= sts_q;
            if (cmd_r == srpg_pkg::CMD_STOP) begin
              target <= direction ? cur - PB'(sts_q) : cur + PB'(sts_q);
            end
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          n_work <= n_sat;
          if (stop_here) begin
            step_interval <= '0;
            speed_mag     <= '0;
            ramp          <= '0;
            state         <= S_FIN;
          end else if (n_sat == 0) begin
            size_work <= first_size;
            direction <= !(tgt_dist > 0);
            state     <= S_SIZE;
          end else begin
            state <= S_DIV_SIZE;
          end
        end
        S_DIV_SIZE: begin
          if (div_done) begin
            size_work <= ns_clamped;
            state     <= S_SIZE;
          end
        end
        S_SIZE: begin
          last_size     <= size_work;
          step_interval <= (size_work[SW-1:16] == '0) ? 24'd1 : size_work[SW-1:16];
          state         <= S_DIV_SPD;
        end
        S_DIV_SPD: begin
          if (div_done) begin
            speed_mag <= sp_q;
            ramp      <= (n_work == 32'sh7FFFFFFF) ? n_work : n_work + 32'sd1;
            state     <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            step_pulse <= pulse_r;
            dir_level  <= (pulse_r ? step_dir_r : direction) ^ reverse;
            position   <= 32'(cur);
            moving     <= (speed_mag != '0) || (target != cur);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  srpg_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (speed_mag),
    .mplier  (speed_mag),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (mul_product)
  );

  srpg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

`ifndef ASSERT_OFF
  a_interval_speed: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> ((step_interval == '0) == (speed_mag == '0)))
    else $error("step interval and speed disagree");

  a_idle_ramp: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && step_interval == '0) |-> ramp == '0)
    else $error("ramp count left over while idle");

  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    last_size != '0)
    else $error("step size reached zero");

  a_mul_start: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy && !div_busy)
    else $error("multiplier started while busy");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

/* tb/sv/stepper_ramp_pulse_generator_top_tb.sv */
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator_top_tb
// Drives ticks and motion commands into the ramp pulse generator under random
// bursts, gaps and output stalls. Each output transaction is checked field by
// field against a fixed typed result or a ramp predictor fed the accepted inputs.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_SPARE     = 3'd5;  // first unused command code
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_TOP = 3'd7;
  localparam int         CYCLE_MAX  = 4000000;
  localparam int         DRAIN_WAIT = 300;
  localparam longint     MASK40     = 64'hFF_FFFF_FFFF;

  typedef struct packed {
    logic               pulse;
    logic               dir;
    logic signed [31:0] pos;
    logic               mov;
  } step_out_t;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] val;
    bit                 typed;
    step_out_t          res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = srpg_pkg::REG_INIT_SIZE;
  logic [srpg_pkg::SIZE_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [2:0]            command = srpg_pkg::CMD_TICK;
  logic signed [31:0]    value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  step_pulse;
  logic                  dir_level;
  logic signed [31:0]    position;
  logic                  moving;

  stepper_ramp_pulse_generator_top i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .command, .value,
    .out_valid, .out_stall, .step_pulse, .dir_level, .position, .moving
  );

  always #5 clk = ~clk;

  // predictor registers and state
  longint m_init, m_min, m_accel, m_rev;
  longint m_pos, m_tgt, m_ramp_n, m_last_sz, m_interval, m_elapsed, m_speed, m_dir;

  step_out_t expected_steps[$];
  int        errors = 0;
  int        burst_left = 0;
  int        hold_req = 0;
  longint    cycles = 0;

  function automatic longint wrap_pos(longint v);
    return longint'($signed(v[31:0]));
  endfunction

  function automatic longint clamp31(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint stopping_steps();
    longint mag, a, q;
    mag = (m_speed < 0) ? -m_speed : m_speed;
    a   = (m_accel == 0) ? 1 : m_accel;
    q   = (mag * mag) / (a << 9);
    return (q > 64'sd2147483647) ? 64'sd2147483647 : q;
  endfunction

  function automatic void ramp_update();
    longint tgt_dist, sts, n, c, ns, sz, fl, sp;
    tgt_dist = wrap_pos(m_tgt - m_pos);
    sts  = stopping_steps();
    n    = m_ramp_n;
    fl   = (m_min == 0) ? 1 : m_min;
    if (tgt_dist == 0 && sts <= 1) begin
      m_interval = 0;
      m_speed    = 0;
      m_ramp_n   = 0;
      return;
    end
    // decide between speeding up and braking against the stopping distance
    if (tgt_dist > 0) begin
      if (n > 0 && (tgt_dist <= sts || m_dir == 1)) n = -sts;
      else if (n < 0 && m_dir == 0 && tgt_dist > sts) n = -n;
    end else if (tgt_dist < 0) begin
      if (n > 0 && (-tgt_dist <= sts || m_dir == 0)) n = -sts;
      else if (n < 0 && m_dir == 1 && -tgt_dist > sts) n = -n;
    end
    n = clamp31(n);
    if (n == 0) begin
      sz    = (m_init == 0) ? 1 : m_init;
      m_dir = (tgt_dist > 0) ? 0 : 1;
    end else begin
      c  = m_last_sz;
      ns = c - (2 * c) / (4 * n + 1);
      if (ns < fl) ns = fl;
      if (ns > MASK40) ns = MASK40;
      sz = ns;
    end
    m_last_sz  = sz;
    m_interval = (sz >> 16) & 64'hFFFF_FFFF;
    if (m_interval == 0) m_interval = 1;
    sp = longint'(srpg_pkg::SPEED_NUM) / sz;
    if (sp > 64'sd2147483647) sp = 64'sd2147483647;
    m_speed  = (m_dir == 1) ? -sp : sp;
    m_ramp_n = clamp31(n + 1);
  endfunction

  function automatic step_out_t predict_step(logic [2:0] cmd, logic signed [31:0] v);
    step_out_t r;
    longint    val, sts;
    logic      pulse, sdir;
    val   = longint'(v);
    pulse = 1'b0;
    sdir  = m_dir[0];
    case (cmd)
      srpg_pkg::CMD_TICK: begin
        if (m_elapsed != 64'hFFFF_FFFF) m_elapsed++;
        if (m_interval != 0 && m_elapsed >= m_interval) begin
          pulse     = 1'b1;
          sdir      = m_dir[0];
          m_pos     = wrap_pos(m_pos + ((m_dir == 0) ? 1 : -1));
          m_elapsed = 0;
          ramp_update();
        end
      end
      srpg_pkg::CMD_MOVE: begin
        m_tgt = val;
        ramp_update();
      end
      srpg_pkg::CMD_SET_POS: begin
        m_pos = val; m_tgt = val; m_ramp_n = 0; m_interval = 0; m_speed = 0;
      end
      srpg_pkg::CMD_STOP: begin
        sts   = stopping_steps();
        m_tgt = wrap_pos(m_pos + ((m_dir == 0) ? sts : -sts));
        ramp_update();
      end
      srpg_pkg::CMD_STOP_NOW: begin
        m_tgt = m_pos; m_speed = 0; m_interval = 0; m_ramp_n = 0;
      end
      default: ;
    endcase
    if (!pulse) sdir = m_dir[0];
    r.pulse = pulse;
    r.dir   = sdir ^ m_rev[0];
    r.pos   = m_pos[31:0];
    r.mov   = (m_speed != 0 || wrap_pos(m_tgt - m_pos) != 0);
    return r;
  endfunction

  // one transaction, with the sender's bursts and gaps
  task automatic offer(logic [2:0] cmd, logic signed [31:0] v, bit typed = 0,
                       step_out_t res = '0);
    step_out_t p;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= v;
    do @(posedge clk); while (in_stall);
    burst_left--;
    p = predict_step(cmd, v);
    expected_steps.push_back(typed ? res : p);
  endtask

  task automatic set_config(longint init, longint min_sz, longint accel, longint rev);
    in_valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= srpg_pkg::REG_INIT_SIZE;
    cfg_data <= init[srpg_pkg::SIZE_W-1:0];
    @(posedge clk);
    cfg_index <= srpg_pkg::REG_MIN_SIZE; cfg_data <= min_sz[srpg_pkg::SIZE_W-1:0];
    @(posedge clk);
    cfg_index <= srpg_pkg::REG_ACCEL; cfg_data <= accel[srpg_pkg::SIZE_W-1:0];
    @(posedge clk);
    cfg_index <= srpg_pkg::REG_REVERSE; cfg_data <= rev[srpg_pkg::SIZE_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    m_init  = init & MASK40;
    m_min   = min_sz & MASK40;
    m_accel = accel & 64'hFF_FFFF;
    m_rev   = rev & 1;
    burst_left = 0;
  endtask

  task automatic random_items(int count);
    int               r;
    logic [2:0]       cmd;
    logic signed [31:0] v;
    repeat (count) begin
      r   = $urandom_range(0, 99);
      v   = $urandom;
      cmd = srpg_pkg::CMD_TICK;
      if (r < 72) cmd = srpg_pkg::CMD_TICK;
      else if (r < 82) begin
        cmd = srpg_pkg::CMD_MOVE;
        v   = m_pos[31:0] + $signed($urandom_range(0, 80)) - 32'sd40;
      end else if (r < 85) cmd = srpg_pkg::CMD_MOVE;
      else if (r < 88) begin
        cmd = srpg_pkg::CMD_SET_POS;
        // park near the wrap point now and then
        if ($urandom_range(0, 1)) v = 32'sh7FFF_FFF0 + $signed($urandom_range(0, 31));
      end else if (r < 92) cmd = srpg_pkg::CMD_STOP;
      else if (r < 95) cmd = srpg_pkg::CMD_STOP_NOW;
      else if (r < 98) cmd = CMD_SPARE + 3'($urandom_range(0, 2));
      offer(cmd, v);
    end
  endtask

  // receiver: stall pattern in modes, plus a long hold-off on request
  int rx_mode = 0, rx_left = 0, hold_seen = 0, hold_cnt = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (out_valid && !out_stall) begin
      if (expected_steps.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction pulse=%0b dir=%0b pos=%0d moving=%0b",
                 $time, step_pulse, dir_level, position, moving);
      end else begin
        step_out_t e;
        e = expected_steps.pop_front();
        if (step_pulse !== e.pulse) begin
          errors++;
          $display("%0t: step_pulse expected %0b actual %0b", $time, e.pulse, step_pulse);
        end
        if (dir_level !== e.dir) begin
          errors++;
          $display("%0t: dir_level expected %0b actual %0b", $time, e.dir, dir_level);
        end
        if (position !== e.pos) begin
          errors++;
          $display("%0t: position expected %0d actual %0d", $time, e.pos, position);
        end
        if (moving !== e.mov) begin
          errors++;
          $display("%0t: moving expected %0b actual %0b", $time, e.mov, moving);
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt  = 3000;
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 400);
    end
    rx_left--;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  stim_row_t directed[] = '{
    '{srpg_pkg::CMD_TICK,     32'sd0,           1, '{1'b0, 1'b0, 32'sd0, 1'b0}},
    '{CMD_SPARE,              32'sh1234_5678,   1, '{1'b0, 1'b0, 32'sd0, 1'b0}},
    '{CMD_SPARE_TOP,          -32'sd1,          1, '{1'b0, 1'b0, 32'sd0, 1'b0}},
    '{srpg_pkg::CMD_SET_POS,  32'sh7FFF_FFFF,   1,
      '{1'b0, 1'b0, 32'sh7FFF_FFFF, 1'b0}},
    '{srpg_pkg::CMD_MOVE,     32'sh8000_0001,   0, '0},
    '{srpg_pkg::CMD_TICK,     -32'sd1,          0, '0},
    '{srpg_pkg::CMD_TICK,     32'sd0,           0, '0},
    '{srpg_pkg::CMD_TICK,     32'sd0,           0, '0},
    '{srpg_pkg::CMD_TICK,     32'sd0,           0, '0},
    '{srpg_pkg::CMD_TICK,     32'sd0,           0, '0},
    '{srpg_pkg::CMD_TICK,     32'sd0,           0, '0},
    '{srpg_pkg::CMD_TICK,     32'sd0,           0, '0},
    '{srpg_pkg::CMD_TICK,     32'sd0,           0, '0},
    '{srpg_pkg::CMD_MOVE,     32'sh7FFF_FFFA,   0, '0},
    '{srpg_pkg::CMD_TICK,     32'sd0,           0, '0},
    '{srpg_pkg::CMD_TICK,     32'sd0,           0, '0},
    '{srpg_pkg::CMD_TICK,     32'sd0,           0, '0},
    '{srpg_pkg::CMD_STOP,     32'sd0,           0, '0},
    '{srpg_pkg::CMD_TICK,     32'sd0,           0, '0},
    '{srpg_pkg::CMD_STOP_NOW, 32'sd0,           0, '0},
    '{srpg_pkg::CMD_SET_POS,  -32'sd2147483648, 0, '0},
    '{srpg_pkg::CMD_MOVE,     -32'sd2147483648, 0, '0},
    '{srpg_pkg::CMD_STOP,     32'sd0,           0, '0},
    '{CMD_SPARE_MID,          32'sd5,           0, '0}
  };

  initial begin
    m_init = srpg_pkg::INIT_SIZE_RST; m_min = srpg_pkg::MIN_SIZE_RST;
    m_accel = srpg_pkg::ACCEL_RST; m_rev = 0;
    m_pos = 0; m_tgt = 0; m_ramp_n = 0; m_last_sz = srpg_pkg::INIT_SIZE_RST;
    m_interval = 0; m_elapsed = 0; m_speed = 0; m_dir = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // the reset rows do not depend on the sizes, so shorten the ramp first
    set_config(64'd4 << 16, 64'd1 << 16, 64'd256, 0);
    foreach (directed[i]) offer(directed[i].cmd, directed[i].val, directed[i].typed,
                                directed[i].res);

    random_items(300);
    hold_req++;                      // long receiver hold-off while items keep coming
    random_items(250);
    set_config(64'd6 << 16 | 64'hABCD, 64'd1, 64'hFF_FFFF, 1);
    random_items(250);
    set_config(64'd1, 64'd1, 64'd1, 0);
    random_items(200);
    set_config(64'd0, 64'd0, 64'd0, 1);
    random_items(150);
    set_config(MASK40, MASK40, 64'd1000, 0);
    random_items(40);
    repeat (3) begin
      longint i0;
      i0 = $urandom_range(1 << 16, 40 << 16);
      set_config(i0, $urandom_range(0, int'(i0)), $urandom_range(1, 24'hFF_FFFF),
                 $urandom_range(0, 1));
      random_items(230);
    end
    in_valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
